// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the debouncer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// File: hdl/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg
// Types and constants shared by the debouncer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tbd_pkg;

  // Item action codes.
  typedef enum logic {
    ACT_BEGIN  = 1'b0,
    ACT_UPDATE = 1'b1
  } action_t;

  // Register word index, taken from paddr[2].
  typedef enum logic {
    REG_INTERVAL = 1'b0,
    REG_LOCK_OUT = 1'b1
  } reg_index_t;

  localparam logic [15:0] INTERVAL_RESET = 16'd10;
  localparam logic        LOCK_OUT_RESET = 1'b0;

  typedef struct packed {
    logic [15:0] interval_ms;
    logic        lock_out_start;
  } cfg_t;

  typedef struct packed {
    logic        debounced_level;
    logic        unstable_level;
    logic        changed_flag;
    logic [31:0] last_raw_change_time;
    logic [31:0] last_debounced_change_time;
    logic [31:0] prior_state_duration;
  } state_t;

endpackage

`default_nettype wire

// File: hdl/tbd_regs.sv
// ----------------------------------------------------------------------------
// tbd_regs
// APB register file holding the stability interval and lock-out mode.
// ----------------------------------------------------------------------------
`default_nettype none

module tbd_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tbd_pkg::cfg_t      cfg
);

  logic                write_en;
  tbd_pkg::reg_index_t index;

  assign pready   = 1'b1;
  assign index    = tbd_pkg::reg_index_t'(paddr[2]);
  assign write_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_ms    <= tbd_pkg::INTERVAL_RESET;
      cfg.lock_out_start <= tbd_pkg::LOCK_OUT_RESET;
    end else if (write_en) begin
      case (index)
        tbd_pkg::REG_INTERVAL: cfg.interval_ms    <= pwdata[15:0];
        tbd_pkg::REG_LOCK_OUT: cfg.lock_out_start <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      tbd_pkg::REG_INTERVAL: prdata = {16'd0, cfg.interval_ms};
      tbd_pkg::REG_LOCK_OUT: prdata = {31'd0, cfg.lock_out_start};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/tbd_step.sv
// ----------------------------------------------------------------------------
// tbd_step
// Next-state logic for one word: stability check, toggle and durations.
// ----------------------------------------------------------------------------
`default_nettype none

module tbd_step (
  input  tbd_pkg::cfg_t   cfg,
  input  tbd_pkg::state_t state,
  input  logic            action,
  input  logic            raw_level,
  input  logic [31:0]     now_ms,
  output tbd_pkg::state_t state_next,
  output logic [31:0]     current_duration
);

  logic [31:0] raw_age;
  logic        stable_edge;

  // Time the raw level has held, modulo 2^32.
  assign raw_age     = now_ms - state.last_raw_change_time;
  assign stable_edge = (raw_level != state.debounced_level) &&
                       (raw_age >= {16'd0, cfg.interval_ms});

  always_comb begin
    state_next              = state;
    state_next.changed_flag = 1'b0;
    if (tbd_pkg::action_t'(action) == tbd_pkg::ACT_BEGIN) begin
      state_next.debounced_level      = raw_level;
      state_next.unstable_level       = raw_level;
      state_next.last_raw_change_time = cfg.lock_out_start ? 32'd0 : now_ms;
    end else begin
      if (stable_edge) begin
        state_next.debounced_level            = ~state.debounced_level;
        state_next.changed_flag               = 1'b1;
        state_next.prior_state_duration       = now_ms - state.last_debounced_change_time;
        state_next.last_debounced_change_time = now_ms;
      end
      // Restart the stability timer on any raw change.
      if (raw_level != state.unstable_level) begin
        state_next.unstable_level       = raw_level;
        state_next.last_raw_change_time = now_ms;
      end
    end
  end

  assign current_duration = now_ms - state_next.last_debounced_change_time;

endmodule

`default_nettype wire

// File: hdl/timed_button_debouncer.sv
// ----------------------------------------------------------------------------
// timed_button_debouncer
// An accepted word's result word is registered and shown on the output in the next cycle.
// Throughput: one word per cycle while result_ready stays high; the state registers update once per word.
// Reset: state clears to zero, interval_ms to 10, lock_out_start to 0.
// No clearing pass: the block is ready in the first cycle after reset.
//
// Debounces a raw button level against a free-running millisecond stamp.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module timed_button_debouncer (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input words
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        action,
  input  logic        raw_level,
  input  logic [31:0] now_ms,
  // Result words
  output logic        result_valid,
  input  logic        result_ready,
  output logic        debounced,
  output logic        changed,
  output logic        rose,
  output logic        fell,
  output logic [31:0] previous_duration,
  output logic [31:0] current_duration
);

  tbd_pkg::cfg_t   cfg;
  tbd_pkg::state_t state;
  tbd_pkg::state_t state_next;
  logic [31:0]     duration_next;
  logic            accept;

  tbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbd_step u_step (
    .cfg              (cfg),
    .state            (state),
    .action           (action),
    .raw_level        (raw_level),
    .now_ms           (now_ms),
    .state_next       (state_next),
    .current_duration (duration_next)
  );

  // Take a new word whenever the result register is empty or being drained.
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // Advance the debouncer state and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      debounced         <= state_next.debounced_level;
      changed           <= state_next.changed_flag;
      previous_duration <= state_next.prior_state_duration;
      current_duration  <= duration_next;
    end
  end

  // Edge flags follow from the level and the toggle flag.
  assign rose = debounced & changed;
  assign fell = ~debounced & changed;

  // Every accepted word shows up as a result in the next cycle.
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, result_valid)
  // A begin word never reports a toggle.
  `ASSERT_NEXT(a_begin_no_toggle, clk, rst,
    accept && (tbd_pkg::action_t'(action) == tbd_pkg::ACT_BEGIN), !changed)
  // A toggle restarts the current-level duration at zero.
  `ASSERT_IMPLIES(a_toggle_zero_duration, clk, rst,
    result_valid && changed, current_duration == 32'd0)

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for timed_button_debouncer. Words carry a raw button
// level and a millisecond stamp. A behavioural debouncer inside the bench
// predicts each result word. The checker compares every field of each result
// against the oldest prediction, under random idling on both channels, a
// long receiver hold-off, and several interval and lock-out settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // One result word as the block presents it.
  typedef struct packed {
    logic        debounced;
    logic        changed;
    logic        rose;
    logic        fell;
    logic [31:0] previous_duration;
    logic [31:0] current_duration;
  } debounce_word_t;

  // Clock, reset and every block input start from known values.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        action = 1'b0;
  logic        raw_level = 1'b0;
  logic [31:0] now_ms = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        debounced;
  logic        changed;
  logic        rose;
  logic        fell;
  logic [31:0] previous_duration;
  logic [31:0] current_duration;

  timed_button_debouncer u_dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .action            (action),
    .raw_level         (raw_level),
    .now_ms            (now_ms),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .debounced         (debounced),
    .changed           (changed),
    .rose              (rose),
    .fell              (fell),
    .previous_duration (previous_duration),
    .current_duration  (current_duration)
  );

  always #6 clk = ~clk;

  // Bench-side copy of the configuration registers.
  logic [15:0] cfg_interval = tbd_pkg::INTERVAL_RESET;
  logic        cfg_lock_out = tbd_pkg::LOCK_OUT_RESET;

  // Bench-side debouncer state, cleared as the block clears it in reset.
  logic        db_level = 1'b0;
  logic        settle_level = 1'b0;
  logic        toggled = 1'b0;
  logic [31:0] raw_change_ms = '0;
  logic [31:0] db_change_ms = '0;
  logic [31:0] held_duration = '0;

  // Predicted result words, oldest first.
  debounce_word_t expected_words[$];

  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          sink_hold = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic [31:0] stamp_ms = '0;

  // Advance the bench debouncer by one word and return the result it gives.
  function automatic debounce_word_t predict_debounce(input tbd_pkg::action_t act,
                                                      input logic raw,
                                                      input logic [31:0] stamp);
    debounce_word_t w;
    if (act == tbd_pkg::ACT_BEGIN) begin
      // Re-initialise from the raw level; the debounced-change history stays.
      db_level      = raw;
      settle_level  = raw;
      toggled       = 1'b0;
      raw_change_ms = cfg_lock_out ? 32'd0 : stamp;
    end else begin
      toggled = 1'b0;
      // Accept a new level once the raw level has held for the interval.
      if (raw != db_level && (stamp - raw_change_ms) >= {16'd0, cfg_interval}) begin
        db_level      = ~db_level;
        toggled       = 1'b1;
        held_duration = stamp - db_change_ms;
        db_change_ms  = stamp;
      end
      // Any raw change restarts the stability timer.
      if (raw != settle_level) begin
        settle_level  = raw;
        raw_change_ms = stamp;
      end
    end
    w.debounced         = db_level;
    w.changed           = toggled;
    w.rose              = db_level & toggled;
    w.fell              = ~db_level & toggled;
    w.previous_duration = held_duration;
    w.current_duration  = stamp - db_change_ms;
    return w;
  endfunction

  // Offer one input word, idling first at the current rate, and predict it
  // once accepted. Valid is left high on return so back-to-back words need
  // only one assignment per edge.
  task automatic send_word(input tbd_pkg::action_t act, input logic raw,
                           input logic [31:0] stamp);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    raw_level  <= raw;
    now_ms     <= stamp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_words.push_back(predict_debounce(act, raw, stamp));
  endtask

  // Drop valid and hold until every predicted word has come back, then let
  // the pipeline settle.
  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Setup then access phase; the register takes the value at the access edge.
  // The bus then idles before return so that a following write starts on a fresh edge.
  task automatic apb_write(input tbd_pkg::reg_index_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tbd_pkg::REG_INTERVAL: cfg_interval = data[15:0];
      tbd_pkg::REG_LOCK_OUT: cfg_lock_out = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Write both registers; the spare upper bits carry junk that must be masked.
  task automatic set_config(input logic [15:0] interval, input logic lock_out);
    apb_write(tbd_pkg::REG_INTERVAL, {16'($urandom), interval});
    apb_write(tbd_pkg::REG_LOCK_OUT, {31'($urandom), lock_out});
  endtask

  task automatic check_word(input debounce_word_t got);
    debounce_word_t want;
    if (expected_words.size() == 0) begin
      $error("result word arrived with nothing expected");
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      if (got.debounced !== want.debounced) begin
        $error("debounced: expected %0d, got %0d", want.debounced, got.debounced);
        mismatches++;
      end
      if (got.changed !== want.changed) begin
        $error("changed: expected %0d, got %0d", want.changed, got.changed);
        mismatches++;
      end
      if (got.rose !== want.rose) begin
        $error("rose: expected %0d, got %0d", want.rose, got.rose);
        mismatches++;
      end
      if (got.fell !== want.fell) begin
        $error("fell: expected %0d, got %0d", want.fell, got.fell);
        mismatches++;
      end
      if (got.previous_duration !== want.previous_duration) begin
        $error("previous_duration: expected %0h, got %0h",
               want.previous_duration, got.previous_duration);
        mismatches++;
      end
      if (got.current_duration !== want.current_duration) begin
        $error("current_duration: expected %0h, got %0h",
               want.current_duration, got.current_duration);
        mismatches++;
      end
    end
  endtask

  // Receiver: check the word taken at this edge, then choose ready for the
  // next one. A requested hold-off is counted down here.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      check_word({debounced, changed, rose, fell, previous_duration, current_duration});
    if (sink_hold > 0) begin
      result_ready <= 1'b0;
      sink_hold--;
    end else begin
      result_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Hand-picked words: wrap of the stamp, a stamp running backwards, bounces
  // that restart the timer, one short of the interval, zero interval,
  // lock-out on begin, the widest interval and the extreme stamps.
  task automatic test_directed();
    send_word(tbd_pkg::ACT_BEGIN,  1'b0, 32'hFFFF_FFF8);
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'hFFFF_FFFA);  // raw change: restart the timer
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'h0000_0003);  // nine ms across the wrap
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'h0000_0004);  // ten ms: rise
    send_word(tbd_pkg::ACT_UPDATE, 1'b0, 32'd5);
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'd6);          // bounce back to one: restart the timer
    send_word(tbd_pkg::ACT_UPDATE, 1'b0, 32'd20);
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'd0);          // stamp runs backwards
    send_word(tbd_pkg::ACT_BEGIN,  1'b1, 32'hFFFF_FFFF);
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'h0000_0000);
    wait_for_results();
    set_config(16'd0, 1'b1);
    send_word(tbd_pkg::ACT_BEGIN,  1'b0, 32'h1234_5678);  // lock-out clears the raw-change time
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'h1234_5678);  // zero interval: immediate rise
    send_word(tbd_pkg::ACT_UPDATE, 1'b0, 32'h1234_5678);  // and an immediate fall
    send_word(tbd_pkg::ACT_UPDATE, 1'b0, 32'hFFFF_FFFF);
    wait_for_results();
    set_config(16'hFFFF, 1'b1);
    send_word(tbd_pkg::ACT_BEGIN,  1'b0, 32'd100);
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'd65534);      // one short of the interval
    send_word(tbd_pkg::ACT_UPDATE, 1'b1, 32'd65534 + 32'd65535);
    wait_for_results();
    set_config(16'hFFFF, 1'b0);
    send_word(tbd_pkg::ACT_BEGIN,  1'b1, 32'hAAAA_5555);
    send_word(tbd_pkg::ACT_UPDATE, 1'b0, 32'h5555_AAAA);
  endtask

  // One press sequence: fresh settings, a begin, then updates with a slowly
  // moving stamp and a bouncing raw level. A few words are pure noise.
  task automatic run_press_sequence(input int n_words);
    int unsigned ival;
    int unsigned step;
    logic        level;
    logic        raw;
    wait_for_results();
    case ($urandom_range(7))
      0:       ival = 0;
      1:       ival = 1;
      2:       ival = 65535;
      3:       ival = $urandom_range(65535);
      default: ival = $urandom_range(40, 2);
    endcase
    set_config(ival[15:0], 1'($urandom_range(1)));
    case ($urandom_range(2))
      0:       stamp_ms = $urandom();
      1:       stamp_ms = 32'hFFFF_FFFF - $urandom_range(4 * ival + 50);
      default: stamp_ms = $urandom_range(200);
    endcase
    level = 1'($urandom_range(1));
    send_word(tbd_pkg::ACT_BEGIN, level, stamp_ms);
    for (int i = 1; i < n_words; i++) begin
      if ($urandom_range(99) < 8) begin
        send_word(tbd_pkg::action_t'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
      end else begin
        if ($urandom_range(99) < 20) level = ~level;
        raw  = ($urandom_range(99) < 30) ? 1'($urandom_range(1)) : level;
        step = ($urandom_range(99) < 5) ? $urandom_range(2 * ival + 5, ival)
                                        : $urandom_range(ival / 3 + 2);
        stamp_ms += step;
        send_word(tbd_pkg::ACT_UPDATE, raw, stamp_ms);
      end
      // Now and then pause the sender until the block has emptied.
      if ($urandom_range(99) < 3) wait_for_results();
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_words);
    int sent;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < n_words) begin
      int len;
      len = $urandom_range(40, 20);
      run_press_sequence(len);
      sent += len;
    end
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // block fills and stalls its input.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    wait_for_results();
    set_config(16'd3, 1'b0);
    sink_hold = 300;
    stamp_ms  = 32'd1000;
    send_word(tbd_pkg::ACT_BEGIN, 1'b0, stamp_ms);
    for (int i = 0; i < 39; i++) begin
      stamp_ms += $urandom_range(4);
      send_word(tbd_pkg::ACT_UPDATE, 1'($urandom_range(1)), stamp_ms);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_traffic(30, 74, 220);
    test_random_traffic(74, 30, 220);
    test_random_traffic(0, 0, 220);
    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
